// File: sv/wcsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wall column span projector.
// Depends on nothing; every other file of the block refers to it by scoped names.
package wcsp_pkg;

  localparam int COLUMN_W   = 10;
  localparam int DIST_W     = 24;
  localparam int SCALE_W    = 32;
  localparam int COLOR_W    = 32;
  localparam int ROW_W      = 11;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Half height is scale * 128 / distance, kept with 8 fraction bits.
  localparam int HALF_SHIFT = 7;
  localparam int FRAC_W     = 8;
  localparam int DIVIDEND_W = SCALE_W + HALF_SHIFT;

  localparam logic [SCALE_W-1:0] RST_PROJ_SCALE   = 32'd35467520;
  localparam logic [ROW_W-1:0]   RST_SCREEN_H     = 11'd600;
  localparam logic [COLOR_W-1:0] RST_CEIL_COLOR   = 32'hFF31_3131;
  localparam logic [COLOR_W-1:0] RST_VWALL_COLOR  = 32'hFFBB_BBBB;
  localparam logic [COLOR_W-1:0] RST_HWALL_COLOR  = 32'hFFEE_EEEE;
  localparam logic [COLOR_W-1:0] RST_FLOOR_COLOR  = 32'hFFA0_A0A0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROJ_SCALE  = 3'd0,
    REG_SCREEN_H    = 3'd1,
    REG_CEIL_COLOR  = 3'd2,
    REG_VWALL_COLOR = 3'd3,
    REG_HWALL_COLOR = 3'd4,
    REG_FLOOR_COLOR = 3'd5
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    SPAN_CEILING = 2'd0,
    SPAN_WALL    = 2'd1,
    SPAN_FLOOR   = 2'd2
  } span_kind_t;

  // Side information that rides along the divider chain with each column.
  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic                vertical_hit;
    logic                sat;
  } item_tag_t;

  // Row boundaries of one column, handed from the divider to the span emitter.
  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic                vertical_hit;
    logic [ROW_W-1:0]    top;
    logic [ROW_W-1:0]    bottom;
    logic [ROW_W-1:0]    height;
  } span_set_t;

  typedef struct packed {
    logic [COLOR_W-1:0] ceiling;
    logic [COLOR_W-1:0] wall_v;
    logic [COLOR_W-1:0] wall_h;
    logic [COLOR_W-1:0] floor_c;
  } color_set_t;

endpackage

// File: sv/wall_column_span_projector_unit.sv
`timescale 1ns / 1ps
// Top level of the wall column span projector: config registers, divider chain, span emitter.
// Depends on wcsp_pkg, wcsp_div_cell and wcsp_span_emit.
//
// Usage: each input transaction (in_column, in_ray_distance in unsigned Q16.8,
// in_vertical_hit) describes one screen column. For each column the block
// sends three output transactions in order: ceiling, wall, floor, each with a
// color, a start row and a row count; out_last_span marks the floor span.
// Empty spans are sent with a length of zero.
// The wall half height is projection_scale * 128 / distance, found by a chain
// of divider cells, one quotient bit per cell, so a column passes one front
// stage, $clog2(MAX_HEIGHT) + 8 cells and the emitter load on its way. The
// front stage loads at the accepting edge. The single output port sends three
// spans per column; the chain accepts a column in any cycle in which it can
// advance.
// When the receiver stalls, the emitter holds its span and the whole chain freezes
// once its last cell is occupied; in_ready then drops. Reset (synchronous, active
// low) empties the chain and the emitter and loads the configuration registers with
// their default values. Configuration is written through cfg_wr_en, cfg_index and
// cfg_data, by the user only while no column is in flight; the block does not enforce this.
module wall_column_span_projector_unit #(
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [wcsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wcsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wcsp_pkg::COLUMN_W-1:0]       in_column,
  input  logic [wcsp_pkg::DIST_W-1:0]         in_ray_distance,
  input  logic                                in_vertical_hit,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wcsp_pkg::COLUMN_W-1:0]       out_column,
  output logic [wcsp_pkg::KIND_W-1:0]         out_span_kind,
  output logic [wcsp_pkg::COLOR_W-1:0]        out_span_color,
  output logic [wcsp_pkg::ROW_W-1:0]          out_span_start,
  output logic [wcsp_pkg::ROW_W-1:0]          out_span_length,
  output logic                                out_last_span
);

  // Row arithmetic width: holds any effective screen height.
  localparam int HB    = $clog2(MAX_HEIGHT) + 1;
  // Quotient bits kept; a larger half height clamps the wall to the full screen.
  localparam int QB    = HB + wcsp_pkg::FRAC_W - 1;
  localparam int NW    = wcsp_pkg::DIVIDEND_W;
  localparam int HI_W  = NW - QB;
  localparam int CMP_W = (HI_W > wcsp_pkg::DIST_W) ? HI_W : wcsp_pkg::DIST_W;
  localparam int DW    = wcsp_pkg::DIST_W;

  // Configuration registers.
  logic [wcsp_pkg::SCALE_W-1:0] cfg_scale_r;
  logic [wcsp_pkg::ROW_W-1:0]   cfg_height_r;
  logic [wcsp_pkg::COLOR_W-1:0] cfg_ceil_r;
  logic [wcsp_pkg::COLOR_W-1:0] cfg_vwall_r;
  logic [wcsp_pkg::COLOR_W-1:0] cfg_hwall_r;
  logic [wcsp_pkg::COLOR_W-1:0] cfg_floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_scale_r  <= wcsp_pkg::RST_PROJ_SCALE;
      cfg_height_r <= wcsp_pkg::RST_SCREEN_H;
      cfg_ceil_r   <= wcsp_pkg::RST_CEIL_COLOR;
      cfg_vwall_r  <= wcsp_pkg::RST_VWALL_COLOR;
      cfg_hwall_r  <= wcsp_pkg::RST_HWALL_COLOR;
      cfg_floor_r  <= wcsp_pkg::RST_FLOOR_COLOR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wcsp_pkg::REG_PROJ_SCALE:  cfg_scale_r  <= cfg_data;
        wcsp_pkg::REG_SCREEN_H:    cfg_height_r <= cfg_data[wcsp_pkg::ROW_W-1:0];
        wcsp_pkg::REG_CEIL_COLOR:  cfg_ceil_r   <= cfg_data;
        wcsp_pkg::REG_VWALL_COLOR: cfg_vwall_r  <= cfg_data;
        wcsp_pkg::REG_HWALL_COLOR: cfg_hwall_r  <= cfg_data;
        wcsp_pkg::REG_FLOOR_COLOR: cfg_floor_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain storage: index 0 is the front register, index k the output of cell k.
  logic                stg_valid [QB+1];
  logic [DW-1:0]       stg_rem   [QB+1];
  logic [DW-1:0]       stg_div   [QB+1];
  logic [QB-1:0]       stg_acc   [QB+1];
  wcsp_pkg::item_tag_t stg_tag   [QB+1];

  logic advance;
  logic emit_ready;

  // The chain moves as one; it halts only when its last cell waits on the emitter.
  assign advance  = !stg_valid[QB] || emit_ready;
  assign in_ready = advance;

  // Front stage: the top dividend bits either fit under the divisor or the
  // quotient overflows the kept width. A zero distance always overflows,
  // which gives the full height wall.
  logic [NW-1:0]       n_full;
  logic [CMP_W-1:0]    hi_cmp;
  logic [CMP_W-1:0]    d_cmp;
  logic                sat;
  wcsp_pkg::item_tag_t front_tag;

  always_comb begin
    n_full              = {cfg_scale_r, {wcsp_pkg::HALF_SHIFT{1'b0}}};
    hi_cmp              = CMP_W'(n_full[NW-1:QB]);
    d_cmp               = CMP_W'(in_ray_distance);
    sat                 = (hi_cmp >= d_cmp);
    front_tag.column       = in_column;
    front_tag.vertical_hit = in_vertical_hit;
    front_tag.sat          = sat;
  end

  logic                front_valid_r;
  logic [DW-1:0]       front_rem_r;
  logic [DW-1:0]       front_div_r;
  logic [QB-1:0]       front_acc_r;
  wcsp_pkg::item_tag_t front_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (advance) begin
      front_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      front_rem_r <= sat ? '0 : hi_cmp[DW-1:0];
      front_div_r <= in_ray_distance;
      front_acc_r <= n_full[QB-1:0];
      front_tag_r <= front_tag;
    end
  end

  assign stg_valid[0] = front_valid_r;
  assign stg_rem[0]   = front_rem_r;
  assign stg_div[0]   = front_div_r;
  assign stg_acc[0]   = front_acc_r;
  assign stg_tag[0]   = front_tag_r;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    wcsp_div_cell #(
      .DIV_W (DW),
      .ACC_W (QB)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .in_valid  (stg_valid[k]),
      .in_rem    (stg_rem[k]),
      .in_div    (stg_div[k]),
      .in_acc    (stg_acc[k]),
      .in_tag    (stg_tag[k]),
      .out_valid (stg_valid[k+1]),
      .out_rem   (stg_rem[k+1]),
      .out_div   (stg_div[k+1]),
      .out_acc   (stg_acc[k+1]),
      .out_tag   (stg_tag[k+1])
    );
  end

  // Row boundaries from the finished quotient (half height, 8 fraction bits).
  logic [HB-1:0]       h_eff;
  logic [HB-1:0]       center;
  logic [HB-1:0]       lower;
  logic [HB-2:0]       down;
  logic [HB-1:0]       up;
  logic [HB-1:0]       top_row;
  logic [HB-1:0]       bottom_row;
  wcsp_pkg::span_set_t span_set;
  wcsp_pkg::color_set_t colors;

  always_comb begin
    if (int'(cfg_height_r) > MAX_HEIGHT) begin
      h_eff = HB'(MAX_HEIGHT);
    end else begin
      h_eff = HB'(cfg_height_r);
    end
    center = h_eff >> 1;
    lower  = h_eff - center;
    down   = stg_acc[QB][QB-1:wcsp_pkg::FRAC_W];
    // Rounding the half height up adds one row when any fraction bit is set.
    up     = HB'(down) + HB'(|stg_acc[QB][wcsp_pkg::FRAC_W-1:0]);
    if (stg_tag[QB].sat || up >= center) begin
      top_row = '0;
    end else begin
      top_row = center - up;
    end
    if (stg_tag[QB].sat || HB'(down) >= lower) begin
      bottom_row = h_eff;
    end else begin
      bottom_row = center + HB'(down);
    end
    span_set.column       = stg_tag[QB].column;
    span_set.vertical_hit = stg_tag[QB].vertical_hit;
    span_set.top          = wcsp_pkg::ROW_W'(top_row);
    span_set.bottom       = wcsp_pkg::ROW_W'(bottom_row);
    span_set.height       = wcsp_pkg::ROW_W'(h_eff);
    colors.ceiling        = cfg_ceil_r;
    colors.wall_v         = cfg_vwall_r;
    colors.wall_h         = cfg_hwall_r;
    colors.floor_c        = cfg_floor_r;
  end

  wcsp_span_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (stg_valid[QB]),
    .in_ready        (emit_ready),
    .in_set          (span_set),
    .colors          (colors),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_column      (out_column),
    .out_span_kind   (out_span_kind),
    .out_span_color  (out_span_color),
    .out_span_start  (out_span_start),
    .out_span_length (out_span_length),
    .out_last_span   (out_last_span)
  );

`ifndef SYNTHESIS
  a_chain_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid[QB] && !emit_ready) |=> stg_valid[QB])
    else $error("column left the divider chain while the emitter was busy");

  a_accept_enters_front: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> front_valid_r)
    else $error("accepted transaction did not enter the front stage");

  a_wall_within_center: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid[QB] |-> (top_row <= center && bottom_row >= center))
    else $error("wall span does not straddle the screen center");
`endif

endmodule

// File: sv/wcsp_div_cell.sv
`timescale 1ns / 1ps
// One cell of the restoring divider chain: resolves one quotient bit per transaction.
// Depends on wcsp_pkg for the tag type.
module wcsp_div_cell #(
  parameter int DIV_W = 24,
  parameter int ACC_W = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [DIV_W-1:0]    in_rem,
  input  logic [DIV_W-1:0]    in_div,
  input  logic [ACC_W-1:0]    in_acc,
  input  wcsp_pkg::item_tag_t in_tag,
  output logic                out_valid,
  output logic [DIV_W-1:0]    out_rem,
  output logic [DIV_W-1:0]    out_div,
  output logic [ACC_W-1:0]    out_acc,
  output wcsp_pkg::item_tag_t out_tag
);

  logic                valid_r;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]    div_r;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  wcsp_pkg::item_tag_t tag_r;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  // The accumulator shifts dividend bits out at the top and quotient bits in below.
  always_comb begin
    trial   = {in_rem, in_acc[ACC_W-1]};
    diff    = trial - {1'b0, in_div};
    ge      = (trial >= {1'b0, in_div});
    rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    acc_nxt = {in_acc[ACC_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      div_r <= in_div;
      acc_r <= acc_nxt;
      tag_r <= in_tag;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_div   = div_r;
  assign out_acc   = acc_r;
  assign out_tag   = tag_r;

endmodule

// File: sv/wcsp_span_emit.sv
`timescale 1ns / 1ps
// Span emitter: turns one column's row boundaries into ceiling, wall and floor transactions.
// Depends on wcsp_pkg for the span kind enum and the boundary and color structs.
module wcsp_span_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wcsp_pkg::span_set_t                 in_set,
  input  wcsp_pkg::color_set_t                colors,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wcsp_pkg::COLUMN_W-1:0]       out_column,
  output logic [wcsp_pkg::KIND_W-1:0]         out_span_kind,
  output logic [wcsp_pkg::COLOR_W-1:0]        out_span_color,
  output logic [wcsp_pkg::ROW_W-1:0]          out_span_start,
  output logic [wcsp_pkg::ROW_W-1:0]          out_span_length,
  output logic                                out_last_span
);

  logic                   hold_r, hold_nxt;
  wcsp_pkg::span_kind_t   kind_r, kind_nxt;
  wcsp_pkg::span_set_t    set_r;
  logic                   load;
  logic                   fire;

  // A new column may enter while the floor span of the previous one is taken.
  assign in_ready = !hold_r || (kind_r == wcsp_pkg::SPAN_FLOOR && out_ready);
  assign load     = in_valid && in_ready;
  assign fire     = hold_r && out_ready;

  always_comb begin
    kind_nxt = kind_r;
    hold_nxt = hold_r;
    if (load) begin
      kind_nxt = wcsp_pkg::SPAN_CEILING;
      hold_nxt = 1'b1;
    end else if (fire) begin
      case (kind_r)
        wcsp_pkg::SPAN_CEILING: kind_nxt = wcsp_pkg::SPAN_WALL;
        wcsp_pkg::SPAN_WALL:    kind_nxt = wcsp_pkg::SPAN_FLOOR;
        wcsp_pkg::SPAN_FLOOR:   hold_nxt = 1'b0;
        default:                hold_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      kind_r <= wcsp_pkg::SPAN_CEILING;
    end else begin
      hold_r <= hold_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      set_r <= in_set;
    end
  end

  always_comb begin
    out_valid     = hold_r;
    out_column    = set_r.column;
    out_span_kind = kind_r;
    out_last_span = 1'b0;
    case (kind_r)
      wcsp_pkg::SPAN_CEILING: begin
        out_span_color  = colors.ceiling;
        out_span_start  = '0;
        out_span_length = set_r.top;
      end
      wcsp_pkg::SPAN_WALL: begin
        out_span_color  = set_r.vertical_hit ? colors.wall_v : colors.wall_h;
        out_span_start  = set_r.top;
        out_span_length = set_r.bottom - set_r.top;
      end
      wcsp_pkg::SPAN_FLOOR: begin
        out_span_color  = colors.floor_c;
        out_span_start  = set_r.bottom;
        out_span_length = set_r.height - set_r.bottom;
        out_last_span   = 1'b1;
      end
      default: begin
        out_span_color  = colors.floor_c;
        out_span_start  = '0;
        out_span_length = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_ceil_then_wall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && kind_r == wcsp_pkg::SPAN_CEILING)
      |=> (out_valid && kind_r == wcsp_pkg::SPAN_WALL))
    else $error("ceiling span not followed by wall span");

  a_wall_then_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && kind_r == wcsp_pkg::SPAN_WALL)
      |=> (out_valid && kind_r == wcsp_pkg::SPAN_FLOOR))
    else $error("wall span not followed by floor span");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (set_r.top <= set_r.bottom && set_r.bottom <= set_r.height))
    else $error("wall rows out of order or beyond screen height");
`endif

endmodule
